@@ src/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg - shared types and constants of the speed calculator
// command word between front and back, result word and status codes
// ----------------------------------------------------------------------------
package csc_pkg;

   // action codes on the request side
   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   // flags byte bits
   localparam int unsigned FLAG_WHEEL_BIT = 0;
   localparam int unsigned FLAG_CRANK_BIT = 1;

   // payload sizes in bytes
   localparam logic [3:0] WHEEL_BYTES = 4'd6;
   localparam logic [3:0] CRANK_BYTES = 4'd4;
   localparam logic [3:0] BYTE_COUNT_MAX = 4'd15;

   localparam logic [9:0]  MM_PER_M   = 10'd1000;
   localparam logic [15:0] CIRC_RESET = 16'd2096;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BASELINE  = 3'd1;
   localparam logic [2:0] ST_NO_UPDATE = 3'd2;
   localparam logic [2:0] ST_NO_WHEEL  = 3'd3;
   localparam logic [2:0] ST_BAD_LEN   = 3'd4;
   localparam logic [2:0] ST_RANGE     = 3'd5;

   // one classified command from the front part
   typedef struct packed {
      logic        is_clear;
      logic        bad_len;
      logic        wheel_present;
      logic        crank_present;
      logic [31:0] wheel_rev;
      logic [15:0] wheel_time;
      logic [15:0] crank_rev;
      logic [15:0] crank_time;
   } csc_cmd_type;

   // one result word
   typedef struct packed {
      logic [2:0]  status;
      logic        speed_valid;
      logic [15:0] speed;
      logic        wheel_present;
      logic        crank_present;
      logic [31:0] wheel_rev;
      logic [15:0] wheel_time;
      logic [15:0] crank_rev;
      logic [15:0] crank_time;
   } csc_result_type;

endpackage

@@ src/csc_front.sv @@
// ----------------------------------------------------------------------------
// csc_front - packet byte assembly
// collects the bytes of a packet, checks its length and emits a command word
// ----------------------------------------------------------------------------
module csc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_action,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last,
   output logic                 q_push,
   output csc_pkg::csc_cmd_type q_cmd,
   input  logic                 q_full
);

   logic [3:0]  byte_count_ff, byte_count_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] wrev_ff, wrev_in;
   logic [15:0] wtime_ff, wtime_in;
   logic [15:0] crev_ff, crev_in;
   logic [15:0] ctime_ff, ctime_in;

   logic       accept;
   logic [3:0] idx;
   logic       wh_cur, cr_cur, wh_new, cr_new;
   logic [3:0] cb;
   logic [3:0] rel;
   logic [1:0] wsel;
   logic [4:0] len;
   logic [4:0] expected;
   logic       bad;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign idx      = byte_count_ff;
   assign wh_cur   = flags_ff[csc_pkg::FLAG_WHEEL_BIT];
   assign cr_cur   = flags_ff[csc_pkg::FLAG_CRANK_BIT];
   assign cb       = wh_cur ? (4'd1 + csc_pkg::WHEEL_BYTES) : 4'd1;
   assign rel      = idx - cb;
   assign wsel     = 2'(idx - 4'd1);
   assign wh_new   = flags_in[csc_pkg::FLAG_WHEEL_BIT];
   assign cr_new   = flags_in[csc_pkg::FLAG_CRANK_BIT];
   assign len      = {1'b0, idx} + 5'd1;
   assign expected = 5'd1 + (wh_new ? 5'(csc_pkg::WHEEL_BYTES) : 5'd0)
                          + (cr_new ? 5'(csc_pkg::CRANK_BYTES) : 5'd0);
   assign bad      = (idx == csc_pkg::BYTE_COUNT_MAX) || (len != expected);

   always_comb begin
      byte_count_in = byte_count_ff;
      flags_in      = flags_ff;
      wrev_in       = wrev_ff;
      wtime_in      = wtime_ff;
      crev_in       = crev_ff;
      ctime_in      = ctime_ff;
      q_push        = 1'b0;
      q_cmd         = '0;
      if (accept) begin
         if (req_action == csc_pkg::ACT_CLEAR) begin
            q_push         = 1'b1;
            q_cmd.is_clear = 1'b1;
         end else begin
            if (idx == 4'd0) begin
               flags_in = req_data_byte;
               wrev_in  = '0;
               wtime_in = '0;
               crev_in  = '0;
               ctime_in = '0;
            end else if (wh_cur && idx >= 4'd1 && idx <= 4'd4) begin
               wrev_in[wsel*8 +: 8] = req_data_byte;
            end else if (wh_cur && idx >= 4'd5 && idx <= 4'd6) begin
               wtime_in[(idx == 4'd6)*8 +: 8] = req_data_byte;
            end else if (cr_cur && idx >= cb && rel < 4'd4) begin
               if (rel[1]) begin
                  ctime_in[rel[0]*8 +: 8] = req_data_byte;
               end else begin
                  crev_in[rel[0]*8 +: 8] = req_data_byte;
               end
            end
            if (byte_count_ff != csc_pkg::BYTE_COUNT_MAX) begin
               byte_count_in = byte_count_ff + 4'd1;
            end
            if (req_last) begin
               byte_count_in = '0;
               q_push        = 1'b1;
               if (bad) begin
                  q_cmd.bad_len = 1'b1;
               end else begin
                  q_cmd.wheel_present = wh_new;
                  q_cmd.crank_present = cr_new;
                  q_cmd.wheel_rev     = wrev_in;
                  q_cmd.wheel_time    = wtime_in;
                  q_cmd.crank_rev     = crev_in;
                  q_cmd.crank_time    = ctime_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         flags_ff      <= '0;
         wrev_ff       <= '0;
         wtime_ff      <= '0;
         crev_ff       <= '0;
         ctime_ff      <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         flags_ff      <= flags_in;
         wrev_ff       <= wrev_in;
         wtime_ff      <= wtime_in;
         crev_ff       <= crev_in;
         ctime_ff      <= ctime_in;
      end
   end

endmodule

@@ src/csc_queue.sv @@
// ----------------------------------------------------------------------------
// csc_queue - command queue
// short register queue between the front and the back part
// ----------------------------------------------------------------------------
module csc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  csc_pkg::csc_cmd_type din,
   output logic                 full,
   input  logic                 pop,
   output csc_pkg::csc_cmd_type dout,
   output logic                 empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   csc_pkg::csc_cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

endmodule

@@ src/csc_back.sv @@
// ----------------------------------------------------------------------------
// csc_back - speed computation
// keeps the wheel baseline, computes rounded speed and holds the result word
// ----------------------------------------------------------------------------
module csc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [15:0]             circ,
   input  logic                    q_empty,
   input  csc_pkg::csc_cmd_type    q_cmd,
   output logic                    q_pop,
   output csc_pkg::csc_result_type rsp_word,
   output logic                    rsp_empty,
   input  logic                    rsp_pop
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_PREP,
      S_CHECK,
      S_DIV,
      S_EMIT
   } state_type;

   state_type   state_ff;
   logic        base_valid_ff;
   logic [31:0] prev_rev_ff;
   logic [15:0] prev_time_ff;
   logic [31:0] drev_ff;
   logic [15:0] dt_ff;
   logic [47:0] prod_ff;
   logic [25:0] den_ff;
   logic [63:0] num_ff;
   logic [41:0] rem_ff;
   logic [40:0] dsh_ff;
   logic [15:0] quo_ff;
   logic [3:0]  iter_ff;
   logic        out_valid_ff;
   csc_pkg::csc_result_type res_ff;
   csc_pkg::csc_result_type out_ff;

   logic [31:0] drev_w;
   logic [15:0] dt_w;
   logic        qbit;
   csc_pkg::csc_result_type res_idle;
   csc_pkg::csc_result_type res_done;

   assign q_pop     = (state_ff == S_IDLE) && !q_empty;
   assign drev_w    = q_cmd.wheel_rev - prev_rev_ff;
   assign dt_w      = q_cmd.wheel_time - prev_time_ff;
   assign qbit      = ({1'b0, dsh_ff} <= rem_ff);
   assign rsp_word  = out_ff;
   assign rsp_empty = !out_valid_ff;

   // word for the command at the queue head, status by the same priority as below
   always_comb begin
      res_idle = '0;
      if (q_cmd.bad_len) begin
         res_idle.status = csc_pkg::ST_BAD_LEN;
      end else begin
         res_idle.wheel_present = q_cmd.wheel_present;
         res_idle.crank_present = q_cmd.crank_present;
         res_idle.wheel_rev     = q_cmd.wheel_rev;
         res_idle.wheel_time    = q_cmd.wheel_time;
         res_idle.crank_rev     = q_cmd.crank_rev;
         res_idle.crank_time    = q_cmd.crank_time;
         if (!q_cmd.wheel_present) begin
            res_idle.status = csc_pkg::ST_NO_WHEEL;
         end else if (!base_valid_ff) begin
            res_idle.status = csc_pkg::ST_BASELINE;
         end else if (dt_w == '0) begin
            res_idle.status = csc_pkg::ST_NO_UPDATE;
         end else begin
            res_idle.status = csc_pkg::ST_OK;
         end
      end
   end

   // word once the last quotient bit is known
   always_comb begin
      res_done             = res_ff;
      res_done.speed_valid = 1'b1;
      res_done.speed       = {quo_ff[14:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_valid_ff <= 1'b0;
         prev_rev_ff   <= '0;
         prev_time_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         // in the emit state the refill below decides the output flag
         if (rsp_pop && out_valid_ff && state_ff != S_EMIT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  if (q_cmd.is_clear) begin
                     base_valid_ff <= 1'b0;
                     prev_rev_ff   <= '0;
                     prev_time_ff  <= '0;
                  end else if (q_cmd.bad_len || !q_cmd.wheel_present) begin
                     res_ff   <= res_idle;
                     state_ff <= S_EMIT;
                  end else if (!base_valid_ff) begin
                     base_valid_ff <= 1'b1;
                     prev_rev_ff   <= q_cmd.wheel_rev;
                     prev_time_ff  <= q_cmd.wheel_time;
                     res_ff        <= res_idle;
                     state_ff      <= S_EMIT;
                  end else if (dt_w == '0) begin
                     res_ff   <= res_idle;
                     state_ff <= S_EMIT;
                  end else begin
                     prev_rev_ff  <= q_cmd.wheel_rev;
                     prev_time_ff <= q_cmd.wheel_time;
                     drev_ff      <= drev_w;
                     dt_ff        <= dt_w;
                     res_ff       <= res_idle;
                     state_ff     <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= drev_ff * circ;
               den_ff   <= dt_ff * csc_pkg::MM_PER_M;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               // times 36864 is times 9 then shift by 12, plus half divisor
               num_ff   <= ({16'b0, prod_ff} << 15) + ({16'b0, prod_ff} << 12)
                           + {38'b0, 1'b0, den_ff[25:1]};
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (num_ff >= {22'b0, den_ff, 16'b0}) begin
                  res_ff.status <= csc_pkg::ST_RANGE;
                  state_ff      <= S_EMIT;
               end else begin
                  rem_ff   <= num_ff[41:0];
                  dsh_ff   <= {den_ff, 15'b0};
                  quo_ff   <= '0;
                  iter_ff  <= 4'd15;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (qbit) begin
                  rem_ff <= rem_ff - {1'b0, dsh_ff};
               end
               dsh_ff <= dsh_ff >> 1;
               quo_ff <= {quo_ff[14:0], qbit};
               if (iter_ff == 4'd0) begin
                  res_ff   <= res_done;
                  state_ff <= S_EMIT;
               end else begin
                  iter_ff <= iter_ff - 4'd1;
               end
            end
            S_EMIT: begin
               if (!out_valid_ff || rsp_pop) begin
                  out_ff       <= res_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_speed_valid_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.speed_valid |-> out_ff.status == csc_pkg::ST_OK)
      else $error("speed marked valid with a non-ok status");

   a_bad_len_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status == csc_pkg::ST_BAD_LEN |->
         !out_ff.wheel_present && !out_ff.crank_present && out_ff.wheel_rev == '0
         && out_ff.speed == '0)
      else $error("bad length word carries data");

   a_div_has_baseline: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> base_valid_ff && den_ff != '0)
      else $error("division without baseline or with zero divisor");

endmodule

@@ src/csc_packet_speed_calc.sv @@
// flow: the front takes one byte per cycle while req_full is low; a status-only packet goes
//   from idle straight to emit in the back part, a speed packet passes multiply, prep, check
//   and the back part's 16-step restoring divider before emit; the back part takes no new
//   command until its result is emitted; a 2-word command queue lets bytes keep flowing
// reset: synchronous, clears framing, baseline, queue and output; circumference 2096 mm
// ----------------------------------------------------------------------------
// csc_packet_speed_calc - cycling speed and cadence packet decoder
// assembles measurement packets byte by byte and computes wheel speed
// ----------------------------------------------------------------------------
module csc_packet_speed_calc #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request side, queue style
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   // result side, queue style
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic        rsp_speed_valid,
   output logic [15:0] rsp_speed_kmh_x10,
   output logic        rsp_wheel_present,
   output logic        rsp_crank_present,
   output logic [31:0] rsp_wheel_revolutions,
   output logic [15:0] rsp_wheel_event_time,
   output logic [15:0] rsp_crank_revolutions,
   output logic [15:0] rsp_crank_event_time,
   // circumference register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wheel_circumference_mm
);

   // wheel circumference register, always writable
   logic [15:0] circ_ff;

   // front to queue
   logic                 f_push;
   csc_pkg::csc_cmd_type f_cmd;
   logic                 q_full;

   // queue to back
   logic                 q_empty;
   logic                 q_pop;
   csc_pkg::csc_cmd_type q_cmd;

   // back output word
   csc_pkg::csc_result_type rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= csc_pkg::CIRC_RESET;
      end else if (csr_valid && csr_ready) begin
         circ_ff <= csr_wheel_circumference_mm;
      end
   end

   // front: framing, byte placement and length check; clear actions pass
   // through as commands so they stay ordered with packets
   csc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .q_push        (f_push),
      .q_cmd         (f_cmd),
      .q_full        (q_full)
   );

   // short queue decoupling the byte stream from the divider
   csc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .din   (f_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_cmd),
      .empty (q_empty)
   );

   // back: baseline, multiply, range check, divide, output register
   csc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .circ      (circ_ff),
      .q_empty   (q_empty),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_word  (rsp_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   // unpack the result word onto the ports
   assign rsp_status            = rsp_word.status;
   assign rsp_speed_valid       = rsp_word.speed_valid;
   assign rsp_speed_kmh_x10     = rsp_word.speed;
   assign rsp_wheel_present     = rsp_word.wheel_present;
   assign rsp_crank_present     = rsp_word.crank_present;
   assign rsp_wheel_revolutions = rsp_word.wheel_rev;
   assign rsp_wheel_event_time  = rsp_word.wheel_time;
   assign rsp_crank_revolutions = rsp_word.crank_rev;
   assign rsp_crank_event_time  = rsp_word.crank_time;

endmodule
